FILE: rtl/pr_pkg.sv
`timescale 1ns / 1ps

package pr_pkg;

    localparam int SEQ_W       = 32;
    localparam int LEN_W       = 11;
    localparam int TAG_BITS    = 10;
    localparam int TAG_W       = TAG_BITS;
    localparam int KIND_W      = 3;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    // window is a power of two; slot = seq mod window
    localparam int SLOT_W      = 5;
    localparam int WINDOW      = 1 << SLOT_W;
    localparam int MAX_PAYLOAD = 1024;
    localparam int RUN_CAP     = 32;
    localparam int CNT_W       = $clog2(RUN_CAP + 1);
    localparam int ENTRY_W     = TAG_W + LEN_W;

    localparam logic [PADDR_W-3:0] REG_START_SEQ = '0;

    typedef enum logic [KIND_W-1:0] {
        K_DELIVER  = 3'd0,
        K_STALE    = 3'd1,
        K_BEYOND   = 3'd2,
        K_REPLACED = 3'd3,
        K_ERROR    = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_FIRST    = 4'b0010,
        S_DRAIN_RD = 4'b0100,
        S_DRAIN_EM = 4'b1000
    } t_state;

    typedef struct packed {
        logic             restart;
        logic [SEQ_W-1:0] start_seq;
    } t_cfg;

endpackage

FILE: rtl/pr_if.sv
`timescale 1ns / 1ps

interface pr_in_if;
    logic                      valid;
    logic                      ready;
    logic [pr_pkg::SEQ_W-1:0]  seq_num;
    logic [pr_pkg::LEN_W-1:0]  payload_len;
    logic [pr_pkg::TAG_W-1:0]  buffer_tag;
    logic                      rx_error;

    modport source (output valid, seq_num, payload_len, buffer_tag, rx_error, input ready);
    modport sink   (input valid, seq_num, payload_len, buffer_tag, rx_error, output ready);
endinterface

interface pr_out_if;
    logic                      valid;
    logic                      ready;
    logic [pr_pkg::KIND_W-1:0] out_kind;
    logic [pr_pkg::SEQ_W-1:0]  out_seq;
    logic [pr_pkg::TAG_W-1:0]  out_tag;
    logic [pr_pkg::LEN_W-1:0]  out_len;
    logic                      last_of_run;

    modport source (output valid, out_kind, out_seq, out_tag, out_len, last_of_run,
                    input ready);
    modport sink   (input valid, out_kind, out_seq, out_tag, out_len, last_of_run,
                    output ready);
endinterface

FILE: rtl/pr_ram.sv
`timescale 1ns / 1ps

module pr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pr_apb_regs.sv
`timescale 1ns / 1ps

module pr_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pr_pkg::PADDR_W-1:0]   paddr,
    input  logic [pr_pkg::DATA_W-1:0]    pwdata,
    output logic [pr_pkg::DATA_W-1:0]    prdata,
    output logic                         pready,
    output pr_pkg::t_cfg                 o_cfg
);

    logic [pr_pkg::SEQ_W-1:0] r_start_seq;
    logic                     r_restart;
    logic                     w_hit;
    logic                     w_wr;

    assign pready = 1'b1;
    assign w_hit  = (paddr[pr_pkg::PADDR_W-1:2] == pr_pkg::REG_START_SEQ);
    assign w_wr   = psel && penable && pwrite && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seq <= '0;
            r_restart   <= 1'b0;
        end else begin
            r_restart <= w_wr;
            if (w_wr) begin
                r_start_seq <= pwdata[pr_pkg::SEQ_W-1:0];
            end
        end
    end

    assign prdata = w_hit ? r_start_seq : '0;

    assign o_cfg.restart   = r_restart;
    assign o_cfg.start_seq = r_start_seq;

endmodule

FILE: rtl/packet_resequencer_unit.sv
`timescale 1ns / 1ps

// channel | dir | handshake     | word
// i_in    | in  | valid/ready   | seq_num, payload_len, buffer_tag, rx_error
// o_out   | out | valid/ready   | out_kind, out_seq, out_tag, out_len, last_of_run
// apb     | in  | psel/penable  | start_seq at byte address 0
//
// A descriptor is accepted in S_IDLE, which starts the slot RAM read, then updated
// in S_FIRST; each drained slot passes S_DRAIN_RD then S_DRAIN_EM (registered RAM read).
// Up to 32 words per descriptor; the input is not taken until its run is done.
// Reset and a start_seq write clear the valid flops at once; no clearing pass.
// The input is held off in the cycle after a start_seq write, while restart is high.
// A full output register with ready low holds the sequencer in S_DRAIN_EM, and in S_FIRST when it has a word to emit.

module packet_resequencer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pr_in_if.sink                        i_in,
    pr_out_if.source                     o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pr_pkg::PADDR_W-1:0]   paddr,
    input  logic [pr_pkg::DATA_W-1:0]    pwdata,
    output logic [pr_pkg::DATA_W-1:0]    prdata,
    output logic                         pready
);

    pr_pkg::t_cfg                   w_cfg;

    pr_pkg::t_state                 r_state, n_state;
    logic [pr_pkg::SEQ_W-1:0]       r_ne, n_ne;
    logic [pr_pkg::WINDOW-1:0]      r_valid, n_valid;
    logic [pr_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    logic [pr_pkg::SEQ_W-1:0]       r_seq;
    logic [pr_pkg::LEN_W-1:0]       r_len;
    logic [pr_pkg::TAG_W-1:0]       r_tag;
    pr_pkg::t_kind                  r_kind;
    logic                           r_store;

    logic                           r_ovalid, n_ovalid;
    pr_pkg::t_kind                  r_okind, n_okind;
    logic [pr_pkg::SEQ_W-1:0]       r_oseq, n_oseq;
    logic [pr_pkg::TAG_W-1:0]       r_otag, n_otag;
    logic [pr_pkg::LEN_W-1:0]       r_olen, n_olen;
    logic                           r_olast, n_olast;

    logic                           w_accept;
    logic [pr_pkg::SEQ_W-1:0]       w_diff;
    logic                           w_err;
    logic [pr_pkg::SLOT_W-1:0]      w_slot;
    logic [pr_pkg::SLOT_W-1:0]      w_ne_slot;
    logic [pr_pkg::SLOT_W-1:0]      w_ne1_slot;
    logic                           w_out_free;
    logic                           w_replace;
    logic                           w_has_first;
    logic [pr_pkg::WINDOW-1:0]      w_mask_ne;
    logic [pr_pkg::WINDOW-1:0]      w_mask_slot;
    logic [pr_pkg::WINDOW-1:0]      w_valid_after;
    logic [pr_pkg::CNT_W-1:0]       w_cnt_after;
    logic                           w_more;
    logic                           w_emit;

    logic                           w_ram_we;
    logic                           w_ram_re;
    logic [pr_pkg::SLOT_W-1:0]      w_ram_raddr;
    logic [pr_pkg::ENTRY_W-1:0]     w_ram_rdata;
    logic [pr_pkg::TAG_W-1:0]       w_rd_tag;
    logic [pr_pkg::LEN_W-1:0]       w_rd_len;

    pr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pr_ram #(
        .WIDTH (pr_pkg::ENTRY_W),
        .DEPTH (pr_pkg::WINDOW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_seq[pr_pkg::SLOT_W-1:0]),
        .i_wdata ({r_tag, r_len}),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_rd_tag = w_ram_rdata[pr_pkg::ENTRY_W-1:pr_pkg::LEN_W];
    assign w_rd_len = w_ram_rdata[pr_pkg::LEN_W-1:0];

    assign i_in.ready = (r_state == pr_pkg::S_IDLE) && !w_cfg.restart;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_diff     = i_in.seq_num - r_ne;
    assign w_err      = i_in.rx_error ||
                        (i_in.payload_len > pr_pkg::LEN_W'(pr_pkg::MAX_PAYLOAD));

    assign w_slot      = r_seq[pr_pkg::SLOT_W-1:0];
    assign w_ne_slot   = r_ne[pr_pkg::SLOT_W-1:0];
    assign w_ne1_slot  = w_ne_slot + 1'b1;
    assign w_out_free  = !r_ovalid || o_out.ready;
    assign w_replace   = r_store && r_valid[w_slot];
    assign w_has_first = !r_store || w_replace;
    assign w_mask_slot = {{(pr_pkg::WINDOW-1){1'b0}}, r_store} << w_slot;
    assign w_mask_ne   = {{(pr_pkg::WINDOW-1){1'b0}}, 1'b1} << w_ne_slot;
    assign w_valid_after = r_valid | w_mask_slot;
    assign w_cnt_after = {{(pr_pkg::CNT_W-1){1'b0}}, w_has_first};

    always_comb begin
        n_state  = r_state;
        n_ne     = r_ne;
        n_valid  = r_valid;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !o_out.ready;
        n_okind  = r_okind;
        n_oseq   = r_oseq;
        n_otag   = r_otag;
        n_olen   = r_olen;
        n_olast  = r_olast;
        w_more   = 1'b0;
        w_emit   = 1'b0;
        w_ram_we = 1'b0;
        w_ram_re = 1'b0;
        w_ram_raddr = w_ne_slot;

        case (r_state)
            pr_pkg::S_IDLE: begin
                w_ram_raddr = i_in.seq_num[pr_pkg::SLOT_W-1:0];
                if (w_accept) begin
                    w_ram_re = 1'b1;
                    n_cnt    = '0;
                    n_state  = pr_pkg::S_FIRST;
                end
            end
            pr_pkg::S_FIRST: begin
                w_more = w_valid_after[w_ne_slot] &&
                         (w_cnt_after < pr_pkg::CNT_W'(pr_pkg::RUN_CAP));
                if (!w_has_first || w_out_free) begin
                    w_ram_we = r_store;
                    n_valid  = w_valid_after;
                    n_cnt    = w_cnt_after;
                    w_emit   = w_has_first;
                    n_state  = w_more ? pr_pkg::S_DRAIN_RD : pr_pkg::S_IDLE;
                    if (w_has_first) begin
                        n_ovalid = 1'b1;
                        n_okind  = w_replace ? pr_pkg::K_REPLACED : r_kind;
                        n_oseq   = r_seq;
                        n_otag   = w_replace ? w_rd_tag : r_tag;
                        n_olen   = w_replace ? w_rd_len : r_len;
                        n_olast  = !w_more;
                    end
                end
            end
            pr_pkg::S_DRAIN_RD: begin
                w_ram_re = 1'b1;
                n_state  = pr_pkg::S_DRAIN_EM;
            end
            pr_pkg::S_DRAIN_EM: begin
                w_more = r_valid[w_ne1_slot] &&
                         ((r_cnt + 1'b1) < pr_pkg::CNT_W'(pr_pkg::RUN_CAP));
                if (w_out_free) begin
                    w_emit   = 1'b1;
                    n_valid  = r_valid & ~w_mask_ne;
                    n_ne     = r_ne + 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    n_ovalid = 1'b1;
                    n_okind  = pr_pkg::K_DELIVER;
                    n_oseq   = r_ne;
                    n_otag   = w_rd_tag;
                    n_olen   = w_rd_len;
                    n_olast  = !w_more;
                    n_state  = w_more ? pr_pkg::S_DRAIN_RD : pr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pr_pkg::S_IDLE;
            end
        endcase

        if (w_cfg.restart) begin
            n_ne    = w_cfg.start_seq;
            n_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pr_pkg::S_IDLE;
            r_ne     <= '0;
            r_valid  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ne     <= n_ne;
            r_valid  <= n_valid;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_okind <= n_okind;
        r_oseq  <= n_oseq;
        r_otag  <= n_otag;
        r_olen  <= n_olen;
        r_olast <= n_olast;
        if (w_accept) begin
            r_seq   <= i_in.seq_num;
            r_len   <= i_in.payload_len;
            r_tag   <= i_in.buffer_tag;
            if (w_err) begin
                r_kind  <= pr_pkg::K_ERROR;
                r_store <= 1'b0;
            end else if (w_diff[pr_pkg::SEQ_W-1]) begin
                r_kind  <= pr_pkg::K_STALE;
                r_store <= 1'b0;
            end else if (w_diff >= pr_pkg::SEQ_W'(pr_pkg::WINDOW)) begin
                r_kind  <= pr_pkg::K_BEYOND;
                r_store <= 1'b0;
            end else begin
                r_kind  <= pr_pkg::K_DELIVER;
                r_store <= 1'b1;
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_kind    = r_okind;
    assign o_out.out_seq     = r_oseq;
    assign o_out.out_tag     = r_otag;
    assign o_out.out_len     = r_olen;
    assign o_out.last_of_run = r_olast;

    a_drain_slot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pr_pkg::S_DRAIN_EM && w_emit) |-> r_valid[w_ne_slot])
        else $error("drained an empty slot");

    a_ne_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pr_pkg::S_DRAIN_EM && w_emit && !w_cfg.restart)
        |=> (r_ne == pr_pkg::SEQ_W'($past(r_ne) + 1'b1)))
        else $error("expected number did not advance by one");

    a_run_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pr_pkg::CNT_W'(pr_pkg::RUN_CAP))
        else $error("run count beyond cap");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_ovalid || o_out.ready))
        else $error("output word overwritten");

endmodule
